/* rtl/u2a_pkg.sv */
// Shared types and constants for the unsigned-to-ASCII digit converter.
package u2a_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned StoreDepth = 32;
  localparam int unsigned StoreAddrW = $clog2(StoreDepth);
  localparam int unsigned CountWidth = 6;
  localparam int unsigned CharWidth  = 6;

  localparam logic [CharWidth-1:0]  AsciiZero = 6'd48;
  // ceil(2^35 / 10): exact quotient for any 32-bit dividend after >> 35
  localparam logic [ValueWidth-1:0] RecipTen  = 32'hCCCC_CCCD;
  localparam int unsigned           RecipShift = 35;

  localparam logic [1:0] CmdBin = 2'd0;
  localparam logic [1:0] CmdOct = 2'd1;
  localparam logic [1:0] CmdDec = 2'd2;

  typedef enum logic [1:0] {
    RadixBin,
    RadixOct,
    RadixDec
  } radix_e;

  typedef enum logic [2:0] {
    SeqIdle,
    SeqShift,
    SeqMul,
    SeqFix,
    SeqEmit
  } seq_state_e;

  typedef struct packed {
    logic [1:0]            command;
    logic [ValueWidth-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CharWidth-1:0]  char_code;
    logic [CountWidth-1:0] digit_count;
    logic                  is_last;
  } out_t;

  typedef struct packed {
    logic   mul_en;
    radix_e radix;
  } div_ctrl_t;

endpackage

/* rtl/u2a_divu.sv */
// Shared divide unit: one digit per step, shift for radix 2/8, reciprocal multiply for 10.
module u2a_divu (
  input  logic                                clk_i,
  input  u2a_pkg::div_ctrl_t                  ctrl_i,
  input  logic [u2a_pkg::ValueWidth-1:0]      val_i,
  output logic [u2a_pkg::ValueWidth-1:0]      quot_o,
  output logic [u2a_pkg::DigitWidth-1:0]      rem_o
);

  localparam int unsigned W  = u2a_pkg::ValueWidth;

  logic [2*W-1:0] prod_q;
  logic [W-1:0]   q10;
  logic [W-1:0]   q10_times_ten;
  logic [W-1:0]   r10;

  // Product register breaks the multiply from the correction step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= (2*W)'(val_i) * (2*W)'(u2a_pkg::RecipTen);
    end
  end

  assign q10           = W'(prod_q[2*W-1:u2a_pkg::RecipShift]);
  assign q10_times_ten = (q10 << 3) + (q10 << 1);
  assign r10           = val_i - q10_times_ten;

  always_comb begin
    case (ctrl_i.radix)
      u2a_pkg::RadixBin: begin
        quot_o = val_i >> 1;
        rem_o  = {3'b000, val_i[0]};
      end
      u2a_pkg::RadixOct: begin
        quot_o = val_i >> 3;
        rem_o  = {1'b0, val_i[2:0]};
      end
      default: begin
        quot_o = q10;
        rem_o  = r10[u2a_pkg::DigitWidth-1:0];
      end
    endcase
  end

endmodule

/* rtl/u2a_digit_mem.sv */
// Digit store: 32 x 4 memory, one write and one registered read port.
module u2a_digit_mem (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [u2a_pkg::StoreAddrW-1:0]      wr_addr_i,
  input  logic [u2a_pkg::DigitWidth-1:0]      wr_data_i,
  input  logic                                rd_en_i,
  input  logic [u2a_pkg::StoreAddrW-1:0]      rd_addr_i,
  output logic [u2a_pkg::DigitWidth-1:0]      rd_data_o
);

  logic [u2a_pkg::DigitWidth-1:0] mem_q [u2a_pkg::StoreDepth];
  logic [u2a_pkg::DigitWidth-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/unsigned_to_ascii_digits_core.sv */
// Top level: sequencer that converts a value to ASCII digits and streams them out.
//
//   channel | signals                          | beat
//   --------+----------------------------------+---------------------------------
//   in      | in_valid_i, in_ready_o, in_data_i  | command + value, one per item
//   out     | out_valid_o, out_ready_i, out_data_o | one ASCII digit, MSD first
//
// Binary/octal write one digit per SeqShift state, decimal one per SeqMul/SeqFix pair
// (multiply by reciprocal, then correct), all through the one divide unit. Emission
// streams one digit per cycle from the digit store via the store read and output
// registers. A stalled output holds its beat and pauses reads. in_ready_o is high only
// between items. Reset is asynchronous, active low, and clears only control state.
module unsigned_to_ascii_digits_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  u2a_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output u2a_pkg::out_t   out_data_o
);

  localparam int unsigned W  = u2a_pkg::ValueWidth;
  localparam int unsigned AW = u2a_pkg::StoreAddrW;
  localparam int unsigned CW = u2a_pkg::CountWidth;
  localparam int unsigned DW = u2a_pkg::DigitWidth;
  localparam int unsigned UsedBits  = (VALUE_BITS > W) ? W : VALUE_BITS;
  localparam logic [W-1:0] ValueMask = W'((64'd1 << UsedBits) - 64'd1);

  u2a_pkg::seq_state_e state_q, state_d;

  logic [W-1:0]   val_q;
  u2a_pkg::radix_e radix_q;
  logic [AW-1:0]  n_q;
  logic [AW-1:0]  rd_ptr_q;
  logic [CW-1:0]  left_q;
  logic [CW-1:0]  count_q;
  logic           rd_vld_q;
  logic           rd_last_q;
  logic           out_vld_q;
  u2a_pkg::out_t  out_q;

  logic            accept;
  logic            mul_en;
  logic            dig_wr;
  logic            div_done;
  logic            load_out;
  logic            rd_en;
  logic [W-1:0]    quot;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   rd_data;
  u2a_pkg::radix_e in_radix;
  u2a_pkg::div_ctrl_t div_ctrl;

  always_comb begin
    case (in_data_i.command)
      u2a_pkg::CmdBin: in_radix = u2a_pkg::RadixBin;
      u2a_pkg::CmdOct: in_radix = u2a_pkg::RadixOct;
      default:         in_radix = u2a_pkg::RadixDec;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    mul_en     = 1'b0;
    dig_wr     = 1'b0;
    case (state_q)
      u2a_pkg::SeqIdle:  in_ready_o = 1'b1;
      u2a_pkg::SeqShift: dig_wr     = 1'b1;
      u2a_pkg::SeqMul:   mul_en     = 1'b1;
      u2a_pkg::SeqFix:   dig_wr     = 1'b1;
      default: ;
    endcase
  end

  assign accept   = in_valid_i && in_ready_o;
  assign div_done = dig_wr && (quot == '0);
  assign load_out = rd_vld_q && (!out_vld_q || out_ready_i);
  assign rd_en    = (state_q == u2a_pkg::SeqEmit) && (left_q != '0)
                    && (!rd_vld_q || load_out);

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      u2a_pkg::SeqIdle: begin
        if (accept) begin
          state_d = (in_radix == u2a_pkg::RadixDec) ? u2a_pkg::SeqMul : u2a_pkg::SeqShift;
        end
      end
      u2a_pkg::SeqShift: begin
        if (div_done) state_d = u2a_pkg::SeqEmit;
      end
      u2a_pkg::SeqMul: state_d = u2a_pkg::SeqFix;
      u2a_pkg::SeqFix: begin
        state_d = div_done ? u2a_pkg::SeqEmit : u2a_pkg::SeqMul;
      end
      u2a_pkg::SeqEmit: begin
        if (load_out && rd_last_q) state_d = u2a_pkg::SeqIdle;
      end
      default: state_d = u2a_pkg::SeqIdle;
    endcase
  end

  assign div_ctrl.mul_en = mul_en;
  assign div_ctrl.radix  = radix_q;

  u2a_divu u_divu (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .val_i  (val_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  u2a_digit_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (dig_wr),
    .wr_addr_i (n_q),
    .wr_data_i (rem),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= u2a_pkg::SeqIdle;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      left_q    <= '0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        rd_vld_q <= 1'b1;
      end else if (load_out) begin
        rd_vld_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (div_done) begin
        left_q <= CW'(n_q) + CW'(1);
      end else if (rd_en) begin
        left_q <= left_q - CW'(1);
      end
    end
  end

  // Datapath: value, digit counter, read pointer and output beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q   <= in_data_i.value & ValueMask;
      radix_q <= in_radix;
      n_q     <= '0;
    end else if (dig_wr) begin
      val_q <= quot;
      n_q   <= n_q + AW'(1);
    end
    if (div_done) begin
      rd_ptr_q <= n_q;
      count_q  <= CW'(n_q) + CW'(1);
    end else if (rd_en) begin
      rd_ptr_q <= rd_ptr_q - AW'(1);
    end
    if (rd_en) begin
      rd_last_q <= (left_q == CW'(1));
    end
    if (load_out) begin
      out_q.char_code   <= u2a_pkg::AsciiZero + u2a_pkg::CharWidth'(rd_data);
      out_q.digit_count <= count_q;
      out_q.is_last     <= rd_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
